/* sv/csc_pkg.sv */
// Shared types, codes and constants of the round-trip clock synchronisation client.
package csc_pkg;

    localparam int SEC_W = 32;
    localparam int NSEC_W = 30;
    localparam int Q_W = 20;
    localparam int RECIP_SHIFT = 40;

    typedef logic [2:0] kind_t;
    localparam kind_t KIND_REQUEST = 3'd0;
    localparam kind_t KIND_GAVE_UP = 3'd1;
    localparam kind_t KIND_SET = 3'd2;
    localparam kind_t KIND_STALE = 3'd3;
    localparam kind_t KIND_TOO_SLOW = 3'd4;
    localparam kind_t KIND_CLOSED = 3'd5;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ATTEMPT_LIMIT = 3'd0;
    localparam cfg_idx_t CFG_MAX_RT_SEC = 3'd1;
    localparam cfg_idx_t CFG_MAX_RT_NSEC = 3'd2;
    localparam cfg_idx_t CFG_DRIFT_FACTOR = 3'd3;
    localparam cfg_idx_t CFG_ACCURACY_BOUND = 3'd4;
    localparam cfg_idx_t CFG_MIN_DELAY = 3'd5;
    localparam cfg_idx_t CFG_SYNC_ALLOWANCE = 3'd6;

    localparam logic [NSEC_W-1:0] NS_IN_SECOND = 30'd1000000000;
    localparam logic [NSEC_W-1:0] HALF_SEC_NSEC = 30'd500000000;
    localparam logic [31:0] US_IN_SECOND = 32'd1000000;
    // Rounded-up reciprocal of 1000 scaled by 2^40; exact for every value below 2^30.
    localparam logic [31:0] RECIP_THOUSAND = 32'd1099511628;

    typedef struct packed {
        logic              op;
        logic [SEC_W-1:0]  now_sec;
        logic [NSEC_W-1:0] now_nsec;
        logic [SEC_W-1:0]  echo_sec;
        logic [NSEC_W-1:0] echo_nsec;
        logic [SEC_W-1:0]  master_sec;
        logic [NSEC_W-1:0] master_nsec;
    } cmd_t;

    typedef struct packed {
        kind_t             kind;
        logic [SEC_W-1:0]  stamp_sec;
        logic [NSEC_W-1:0] stamp_nsec;
        logic [SEC_W-1:0]  set_sec;
        logic [NSEC_W-1:0] set_nsec;
        logic [31:0]       delay_us;
        logic [31:0]       next_sync_delay;
    } res_t;

    typedef struct packed {
        logic [7:0]        attempt_limit;
        logic [SEC_W-1:0]  max_round_trip_sec;
        logic [NSEC_W-1:0] max_round_trip_nsec;
        logic [31:0]       drift_factor;
        logic [31:0]       accuracy_bound;
        logic [31:0]       min_delay;
        logic [31:0]       sync_allowance;
    } cfg_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

endpackage

/* sv/csc_if.sv */
// Valid/ready channel interfaces for the request and result items.
interface csc_cmd_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] now_sec;
    logic [29:0] now_nsec;
    logic [31:0] echo_sec;
    logic [29:0] echo_nsec;
    logic [31:0] master_sec;
    logic [29:0] master_nsec;

    modport source (
        output valid, op, now_sec, now_nsec, echo_sec, echo_nsec, master_sec, master_nsec,
        input  ready
    );
    modport sink (
        input  valid, op, now_sec, now_nsec, echo_sec, echo_nsec, master_sec, master_nsec,
        output ready
    );
endinterface

interface csc_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] stamp_sec;
    logic [29:0] stamp_nsec;
    logic [31:0] set_sec;
    logic [29:0] set_nsec;
    logic [31:0] delay_us;
    logic [31:0] next_sync_delay;

    modport source (
        output valid, kind, stamp_sec, stamp_nsec, set_sec, set_nsec, delay_us,
               next_sync_delay,
        input  ready
    );
    modport sink (
        input  valid, kind, stamp_sec, stamp_nsec, set_sec, set_nsec, delay_us,
               next_sync_delay,
        output ready
    );
endinterface

/* sv/round_trip_clock_sync_client_top.sv */
// Top level of the round-trip clock synchronisation client: configuration, channels, result register.
// The block handles one request at a time under a small sequencer that drives a single
// shared 32 by 32 bit multiplier. A send tick, a stale response or any request once the
// block is closed is answered straight from the idle state. A matching response is first
// normalised, halved and turned into microseconds by two passes through the multiplier;
// if it is too slow it is reported then, else the set time is normalised and a third pass
// scales the next sync delay. A finished result waits in an output register, so the next
// request is taken while it is still unread.
module round_trip_clock_sync_client_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  csc_pkg::cfg_idx_t cfg_index,
    input  logic [31:0]       cfg_data,
    csc_cmd_if.sink           cmd,
    csc_res_if.source         res
);
    import csc_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    cmd_t  cmd_item;
    res_t  core_result;
    res_t  res_reg;
    logic  res_valid_reg;
    logic  core_valid;
    logic  core_ready;
    logic  take;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ATTEMPT_LIMIT:  cfg_next.attempt_limit = cfg_data[7:0];
                CFG_MAX_RT_SEC:     cfg_next.max_round_trip_sec = cfg_data;
                CFG_MAX_RT_NSEC:    cfg_next.max_round_trip_nsec = cfg_data[NSEC_W-1:0];
                CFG_DRIFT_FACTOR:   cfg_next.drift_factor = cfg_data;
                CFG_ACCURACY_BOUND: cfg_next.accuracy_bound = cfg_data;
                CFG_MIN_DELAY:      cfg_next.min_delay = cfg_data;
                CFG_SYNC_ALLOWANCE: cfg_next.sync_allowance = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attempt_limit <= 8'd4;
            cfg_reg.max_round_trip_sec <= 32'd0;
            cfg_reg.max_round_trip_nsec <= 30'd100000000;
            cfg_reg.drift_factor <= 32'd1;
            cfg_reg.accuracy_bound <= 32'd1000000;
            cfg_reg.min_delay <= 32'd0;
            cfg_reg.sync_allowance <= 32'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cmd_item.op = cmd.op;
    assign cmd_item.now_sec = cmd.now_sec;
    assign cmd_item.now_nsec = cmd.now_nsec;
    assign cmd_item.echo_sec = cmd.echo_sec;
    assign cmd_item.echo_nsec = cmd.echo_nsec;
    assign cmd_item.master_sec = cmd.master_sec;
    assign cmd_item.master_nsec = cmd.master_nsec;
    assign cmd.ready = core_ready;

    assign take = !res_valid_reg || res.ready;

    csc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd_valid    (cmd.valid),
        .cmd_ready    (core_ready),
        .cmd_item     (cmd_item),
        .result_valid (core_valid),
        .result       (core_result),
        .result_take  (take)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (core_valid && take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_valid && take)
        begin
            res_reg <= core_result;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.kind = res_reg.kind;
    assign res.stamp_sec = res_reg.stamp_sec;
    assign res.stamp_nsec = res_reg.stamp_nsec;
    assign res.set_sec = res_reg.set_sec;
    assign res.set_nsec = res_reg.set_nsec;
    assign res.delay_us = res_reg.delay_us;
    assign res.next_sync_delay = res_reg.next_sync_delay;

endmodule

/* sv/csc_mul.sv */
// Shared 32 by 32 bit multiplier with a registered product.
module csc_mul (
    input  logic              clk,
    input  csc_pkg::mul_req_t req,
    output logic [63:0]       prod
);
    import csc_pkg::*;

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= {32'd0, req.a} * {32'd0, req.b};
    end

    assign prod = prod_reg;

endmodule

/* sv/csc_core.sv */
// Sequencer, synchronisation state and arithmetic registers around the shared multiplier.
module csc_core (
    input  logic          clk,
    input  logic          rst_n,
    input  csc_pkg::cfg_t cfg,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  csc_pkg::cmd_t cmd_item,
    output logic          result_valid,
    output csc_pkg::res_t result,
    input  logic          result_take
);
    import csc_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_NORM = 4'd1;
    localparam logic [3:0] ST_HALF = 4'd2;
    localparam logic [3:0] ST_MQ   = 4'd3;
    localparam logic [3:0] ST_MD   = 4'd4;
    localparam logic [3:0] ST_D    = 4'd5;
    localparam logic [3:0] ST_SETN = 4'd6;
    localparam logic [3:0] ST_T    = 4'd7;
    localparam logic [3:0] ST_DM   = 4'd8;
    localparam logic [3:0] ST_DNS  = 4'd9;
    localparam logic [3:0] ST_EMIT = 4'd10;

    localparam logic [31:0] NS_IN_SECOND_W = {2'b00, NS_IN_SECOND};
    localparam logic [30:0] NS_IN_SECOND_S = {1'b0, NS_IN_SECOND};

    logic [3:0]        state_reg, state_next;
    logic              closed_reg, closed_next;
    logic [7:0]        attempts_reg, attempts_next;
    logic [SEC_W-1:0]  pend_sec_reg, pend_sec_next;
    logic [NSEC_W-1:0] pend_nsec_reg, pend_nsec_next;
    kind_t             kind_reg, kind_next;

    logic [31:0]       rt_s_reg, rt_s_next;
    logic [31:0]       rt_n_reg, rt_n_next;
    logic              fast_reg, fast_next;
    logic [30:0]       hs_reg, hs_next;
    logic [NSEC_W-1:0] hn_reg, hn_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [31:0]       d_reg, d_next;
    logic [SEC_W-1:0]  set_s_reg, set_s_next;
    logic [30:0]       sn_reg, sn_next;
    logic [31:0]       t_reg, t_next;
    logic [SEC_W-1:0]  mas_s_reg, mas_s_next;
    logic [NSEC_W-1:0] mas_n_reg, mas_n_next;

    mul_req_t    mul_req;
    logic [63:0] prod;

    csc_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    assign cmd_ready = (state_reg == ST_IDLE);
    assign result_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        state_next = state_reg;
        closed_next = closed_reg;
        attempts_next = attempts_reg;
        pend_sec_next = pend_sec_reg;
        pend_nsec_next = pend_nsec_reg;
        kind_next = kind_reg;
        rt_s_next = rt_s_reg;
        rt_n_next = rt_n_reg;
        fast_next = fast_reg;
        hs_next = hs_reg;
        hn_next = hn_reg;
        q_next = q_reg;
        d_next = d_reg;
        set_s_next = set_s_reg;
        sn_next = sn_reg;
        t_next = t_reg;
        mas_s_next = mas_s_reg;
        mas_n_next = mas_n_reg;
        mul_req = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    mas_s_next = cmd_item.master_sec;
                    mas_n_next = cmd_item.master_nsec;
                    rt_s_next = cmd_item.now_sec - cmd_item.echo_sec;
                    rt_n_next = {2'b00, cmd_item.now_nsec} - {2'b00, cmd_item.echo_nsec};
                    state_next = ST_EMIT;
                    if (closed_reg)
                    begin
                        kind_next = KIND_CLOSED;
                    end
                    else if (cmd_item.op == OP_SEND)
                    begin
                        if (attempts_reg >= cfg.attempt_limit)
                        begin
                            closed_next = 1'b1;
                            kind_next = KIND_GAVE_UP;
                        end
                        else
                        begin
                            attempts_next = attempts_reg + 8'd1;
                            pend_sec_next = cmd_item.now_sec;
                            pend_nsec_next = cmd_item.now_nsec;
                            kind_next = KIND_REQUEST;
                        end
                    end
                    else if (pend_sec_reg != cmd_item.echo_sec ||
                             pend_nsec_reg != cmd_item.echo_nsec)
                    begin
                        kind_next = KIND_STALE;
                    end
                    else
                    begin
                        state_next = ST_NORM;
                    end
                end
            end
            ST_NORM:
            begin
                if (rt_n_reg[31])
                begin
                    rt_n_next = rt_n_reg + NS_IN_SECOND_W;
                    rt_s_next = rt_s_reg - 32'd1;
                end
                else if (rt_n_reg >= NS_IN_SECOND_W)
                begin
                    rt_n_next = rt_n_reg - NS_IN_SECOND_W;
                    rt_s_next = rt_s_reg + 32'd1;
                end
                else
                begin
                    state_next = ST_HALF;
                end
            end
            ST_HALF:
            begin
                hs_next = rt_s_reg[31:1];
                hn_next = {1'b0, rt_n_reg[NSEC_W-1:1]} +
                          (rt_s_reg[0] ? HALF_SEC_NSEC : '0);
                fast_next = (rt_s_reg < cfg.max_round_trip_sec) ||
                            (rt_s_reg == cfg.max_round_trip_sec &&
                             rt_n_reg[NSEC_W-1:0] < cfg.max_round_trip_nsec);
                state_next = ST_MQ;
            end
            ST_MQ:
            begin
                mul_req.a = {2'b00, hn_reg};
                mul_req.b = RECIP_THOUSAND;
                state_next = ST_MD;
            end
            ST_MD:
            begin
                q_next = prod[RECIP_SHIFT +: Q_W];
                mul_req.a = {1'b0, hs_reg};
                mul_req.b = US_IN_SECOND;
                state_next = ST_D;
            end
            ST_D:
            begin
                d_next = prod[31:0] + {{(32-Q_W){1'b0}}, q_reg} + 32'd1;
                if (fast_reg)
                begin
                    set_s_next = mas_s_reg + {1'b0, hs_reg};
                    sn_next = {1'b0, mas_n_reg} + {1'b0, hn_reg};
                    state_next = ST_SETN;
                end
                else
                begin
                    kind_next = KIND_TOO_SLOW;
                    state_next = ST_EMIT;
                end
            end
            ST_SETN:
            begin
                if (sn_reg >= NS_IN_SECOND_S)
                begin
                    sn_next = sn_reg - NS_IN_SECOND_S;
                    set_s_next = set_s_reg + 32'd1;
                end
                else
                begin
                    state_next = ST_T;
                end
            end
            ST_T:
            begin
                t_next = cfg.accuracy_bound - d_reg + cfg.min_delay;
                state_next = ST_DM;
            end
            ST_DM:
            begin
                mul_req.a = cfg.drift_factor;
                mul_req.b = t_reg;
                state_next = ST_DNS;
            end
            ST_DNS:
            begin
                t_next = prod[31:0] - cfg.sync_allowance;
                attempts_next = 8'd0;
                pend_sec_next = '0;
                pend_nsec_next = '0;
                kind_next = KIND_SET;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (result_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result.kind = kind_reg;
        result.stamp_sec = (kind_reg == KIND_REQUEST) ? pend_sec_reg : '0;
        result.stamp_nsec = (kind_reg == KIND_REQUEST) ? pend_nsec_reg : '0;
        result.set_sec = (kind_reg == KIND_SET) ? set_s_reg : '0;
        result.set_nsec = (kind_reg == KIND_SET) ? sn_reg[NSEC_W-1:0] : '0;
        result.delay_us = (kind_reg == KIND_SET || kind_reg == KIND_TOO_SLOW) ? d_reg : '0;
        result.next_sync_delay = (kind_reg == KIND_SET) ? t_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            closed_reg <= 1'b0;
            attempts_reg <= '0;
            pend_sec_reg <= '0;
            pend_nsec_reg <= '0;
            kind_reg <= KIND_REQUEST;
        end
        else
        begin
            state_reg <= state_next;
            closed_reg <= closed_next;
            attempts_reg <= attempts_next;
            pend_sec_reg <= pend_sec_next;
            pend_nsec_reg <= pend_nsec_next;
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rt_s_reg <= rt_s_next;
        rt_n_reg <= rt_n_next;
        fast_reg <= fast_next;
        hs_reg <= hs_next;
        hn_reg <= hn_next;
        q_reg <= q_next;
        d_reg <= d_next;
        set_s_reg <= set_s_next;
        sn_reg <= sn_next;
        t_reg <= t_next;
        mas_s_reg <= mas_s_next;
        mas_n_reg <= mas_n_next;
    end

endmodule
